[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/agc_pkg.sv]
`default_nettype none

package agc_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic [6:0]  tilt_limit;
		logic [15:0] freefall_level;
		logic [15:0] shock3_level;
		logic [15:0] shock6_level;
		logic [15:0] shock8_level;
		logic [3:0]  shock_hold;
		logic [1:0]  confirm_count;
	} agc_cfg_t;

endpackage

`default_nettype wire

[src/accel_gesture_classifier_core.sv]
// Channel | Handshake          | Payload
// --------+--------------------+-------------------------------------
// in      | in_valid/in_ready  | accel_x, accel_y, accel_z (signed)
// out     | out_valid/out_ready| gesture, event_valid, force_res
// cfg     | APB psel/penable   | paddr, pwdata, prdata (pready tied 1)
//
// One transfer per cycle in each direction while out_ready is high. A sample is
// registered in stage 1, then squares, shock counters and the classifier run in
// one combinational pass into the stage 2 result register.
// Reset (arst_n low) clears all gesture/shock state and loads the default config.
// A stall on out holds stage 2; an empty stage 1 takes one more sample, then
// in_ready stays low until out_ready frees stage 2.
`default_nettype none

module accel_gesture_classifier_core #(
	parameter int unsigned AXIS_WIDTH = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// sample input
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [AXIS_WIDTH-1:0] accel_x,
	input  wire logic signed [AXIS_WIDTH-1:0] accel_y,
	input  wire logic signed [AXIS_WIDTH-1:0] accel_z,
	// result output
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [3:0]                        gesture,
	output logic                              event_valid,
	output logic [15:0]                       force_res,
	// config port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [agc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [agc_pkg::DATA_W-1:0]   pwdata,
	output logic      [agc_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);
	import agc_pkg::*;

	`include "assert_macros.svh"

	// force = x^2+y^2+z^2 needs 2*AW+2 bits; compare against 16-bit levels
	localparam int unsigned SQ_W  = 2 * AXIS_WIDTH;
	localparam int unsigned FRC_W = SQ_W + 2;
	localparam int unsigned CMP_W = (FRC_W > 16) ? FRC_W : 16;
	// axis vs. tilt limit (7-bit unsigned) compare width
	localparam int unsigned LIM_W = ((AXIS_WIDTH > 8) ? AXIS_WIDTH : 8) + 1;

	typedef enum logic [3:0] {
		GEST_NONE      = 4'd0,
		GEST_RIGHT     = 4'd1,
		GEST_LEFT      = 4'd2,
		GEST_DOWN      = 4'd3,
		GEST_UP        = 4'd4,
		GEST_FACE_UP   = 4'd5,
		GEST_FACE_DOWN = 4'd6,
		GEST_FALL      = 4'd7,
		GEST_SHOCK3    = 4'd8,
		GEST_SHOCK6    = 4'd9,
		GEST_SHOCK8    = 4'd10
	} gest_t;

	agc_cfg_t cfg;

	agc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------------
	logic                         valid_s1;
	logic signed [AXIS_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic                         valid_s2;
	logic                         fire;

	// stage 1 moves into stage 2 when stage 2 is empty or being drained
	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1 <= accel_x;
			y_s1 <= accel_y;
			z_s1 <= accel_z;
		end
	end

	// ---------------------------------------------------------------------
	// Force: three parallel squares and a sum
	// ---------------------------------------------------------------------
	logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
	logic [FRC_W-1:0]       force_sum;
	logic [CMP_W-1:0]       force_ext;

	assign sq_x = SQ_W'(x_s1) * SQ_W'(x_s1);
	assign sq_y = SQ_W'(y_s1) * SQ_W'(y_s1);
	assign sq_z = SQ_W'(z_s1) * SQ_W'(z_s1);
	// squares are never negative, so the sign bit is always zero
	assign force_sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
	assign force_ext = CMP_W'(force_sum);

	// ---------------------------------------------------------------------
	// Shock detectors: 0 = 3g, 1 = 6g, 2 = 8g
	// ---------------------------------------------------------------------
	logic [2:0][3:0]  cnt_q, cnt_adv, cnt_d;
	logic [2:0][15:0] shock_lvl;
	logic [2:0]       shock_start;
	logic             any_clr;

	assign shock_lvl[0] = cfg.shock3_level;
	assign shock_lvl[1] = cfg.shock6_level;
	assign shock_lvl[2] = cfg.shock8_level;

	// A running counter that passes the hold limit clears all three. The clear
	// test only looks at pre-sample values, so the 3g/6g/8g ordering collapses
	// to "any passes -> all zero, else every running one steps".
	always_comb begin
		any_clr = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (cnt_q[i] != 4'd0 && ({1'b0, cnt_q[i]} + 5'd1) > {1'b0, cfg.shock_hold}) begin
				any_clr = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (any_clr) begin
				cnt_adv[i] = 4'd0;
			end else if (cnt_q[i] != 4'd0) begin
				cnt_adv[i] = cnt_q[i] + 4'd1;
			end else begin
				cnt_adv[i] = cnt_q[i];
			end
			shock_start[i] = (cnt_adv[i] == 4'd0) && (force_ext > CMP_W'(shock_lvl[i]));
			cnt_d[i]       = shock_start[i] ? 4'd1 : cnt_adv[i];
		end
	end

	// ---------------------------------------------------------------------
	// Orientation classifier and confirmation
	// ---------------------------------------------------------------------
	logic signed [LIM_W-1:0] x_w, y_w, z_w, lim_pos, lim_neg;
	gest_t                   inst;
	gest_t                   held_q, held_d;
	gest_t                   cand_q, cand_d;
	logic [1:0]              run_q, run_d;
	logic                    event_d;

	assign x_w     = LIM_W'(x_s1);
	assign y_w     = LIM_W'(y_s1);
	assign z_w     = LIM_W'(z_s1);
	assign lim_pos = $signed({{(LIM_W-7){1'b0}}, cfg.tilt_limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (force_ext < CMP_W'(cfg.freefall_level)) inst = GEST_FALL;
		else if (x_w < lim_neg)                    inst = GEST_RIGHT;
		else if (x_w > lim_pos)                    inst = GEST_LEFT;
		else if (y_w < lim_neg)                    inst = GEST_DOWN;
		else if (y_w > lim_pos)                    inst = GEST_UP;
		else if (z_w < lim_neg)                    inst = GEST_FACE_UP;
		else if (z_w > lim_pos)                    inst = GEST_FACE_DOWN;
		else                                       inst = GEST_NONE;
	end

	always_comb begin
		held_d  = held_q;
		cand_d  = cand_q;
		run_d   = run_q;
		event_d = 1'b0;
		if (shock_start != 3'b000) begin
			// highest detector that starts wins; classifier is bypassed
			if (shock_start[2])      held_d = GEST_SHOCK8;
			else if (shock_start[1]) held_d = GEST_SHOCK6;
			else                     held_d = GEST_SHOCK3;
			event_d = 1'b1;
		end else begin
			if (inst == cand_q) begin
				if (run_q < cfg.confirm_count) run_d = run_q + 2'd1;
			end else begin
				cand_d = inst;
				run_d  = 2'd0;
			end
			if (cand_d != held_q && run_d >= cfg.confirm_count) begin
				held_d  = cand_d;
				event_d = (cand_d != GEST_NONE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			held_q <= GEST_NONE;
			cand_q <= GEST_NONE;
			run_q  <= 2'd0;
		end else if (fire) begin
			cnt_q  <= cnt_d;
			held_q <= held_d;
			cand_q <= cand_d;
			run_q  <= run_d;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: result register
	// ---------------------------------------------------------------------
	gest_t       gesture_s2;
	logic        event_s2;
	logic [15:0] force_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			gesture_s2 <= held_d;
			event_s2   <= event_d;
			force_s2   <= force_ext[15:0];
		end
	end

	assign out_valid   = valid_s2;
	assign gesture     = gesture_s2;
	assign event_valid = event_s2;
	assign force_res   = force_s2;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`AGC_ASSERT_NOW(a_event_has_gesture, valid_s2 && event_s2, gesture_s2 != GEST_NONE,
		"event raised for no gesture")
	`AGC_ASSERT_NEXT(a_shock_sets_gesture, fire && shock_start != 3'b000,
		event_s2 && gesture_s2 >= GEST_SHOCK3, "shock start did not set a shock gesture")
	`AGC_ASSERT_NEXT(a_clear_all, fire && any_clr,
		cnt_q[0] <= 4'd1 && cnt_q[1] <= 4'd1 && cnt_q[2] <= 4'd1,
		"shock counters not cleared together")
	`AGC_ASSERT_NOW(a_empty_takes, !valid_s1, in_ready, "input stalled with empty stage 1")

endmodule

`default_nettype wire

[src/agc_cfg_regs.sv]
`default_nettype none

module agc_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [agc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [agc_pkg::DATA_W-1:0] pwdata,
	output logic      [agc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output agc_pkg::agc_cfg_t               cfg
);
	import agc_pkg::*;

	typedef enum logic [2:0] {
		REG_TILT     = 3'd0,
		REG_FREEFALL = 3'd1,
		REG_SHOCK3   = 3'd2,
		REG_SHOCK6   = 3'd3,
		REG_SHOCK8   = 3'd4,
		REG_HOLD     = 3'd5,
		REG_CONFIRM  = 3'd6
	} reg_idx_t;

	agc_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_limit     <= 7'd80;
			cfg_q.freefall_level <= 16'd1600;
			cfg_q.shock3_level   <= 16'd18225;
			cfg_q.shock6_level   <= 16'd32400;
			cfg_q.shock8_level   <= 16'd40000;
			cfg_q.shock_hold     <= 4'd5;
			cfg_q.confirm_count  <= 2'd2;
		end else if (wr_en) begin
			unique case (idx)
				REG_TILT:     cfg_q.tilt_limit     <= pwdata[6:0];
				REG_FREEFALL: cfg_q.freefall_level <= pwdata[15:0];
				REG_SHOCK3:   cfg_q.shock3_level   <= pwdata[15:0];
				REG_SHOCK6:   cfg_q.shock6_level   <= pwdata[15:0];
				REG_SHOCK8:   cfg_q.shock8_level   <= pwdata[15:0];
				REG_HOLD:     cfg_q.shock_hold     <= pwdata[3:0];
				REG_CONFIRM:  cfg_q.confirm_count  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TILT:     prdata = {25'd0, cfg_q.tilt_limit};
			REG_FREEFALL: prdata = {16'd0, cfg_q.freefall_level};
			REG_SHOCK3:   prdata = {16'd0, cfg_q.shock3_level};
			REG_SHOCK6:   prdata = {16'd0, cfg_q.shock6_level};
			REG_SHOCK8:   prdata = {16'd0, cfg_q.shock8_level};
			REG_HOLD:     prdata = {28'd0, cfg_q.shock_hold};
			REG_CONFIRM:  prdata = {30'd0, cfg_q.confirm_count};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire
